// ===== src/fbpa_pkg.sv =====
// shared types, codes and defaults of the fixed block pool allocator
package fbpa_pkg;

   localparam int MAX_BLOCKS_DEF = 256;
   localparam int ADDR_BITS_DEF  = 32;

   localparam logic [1:0] REQ_ALLOC   = 2'd0;
   localparam logic [1:0] REQ_FREE    = 2'd1;
   localparam logic [1:0] REQ_REBUILD = 2'd2;

   localparam logic [1:0] STATUS_DONE      = 2'd0;
   localparam logic [1:0] STATUS_TOO_BIG   = 2'd1;
   localparam logic [1:0] STATUS_EXHAUSTED = 2'd2;
   localparam logic [1:0] STATUS_FULL      = 2'd3;

   localparam logic [1:0] CSR_POOL_BASE   = 2'd0;
   localparam logic [1:0] CSR_BLOCK_BYTES = 2'd1;
   localparam logic [1:0] CSR_POOL_BLOCKS = 2'd2;

   localparam logic [24:0] BYTES_MAX = 25'h1FFFFFF;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [23:0] request_bytes;
      logic [31:0] returned_address;
   } req_beat_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] block_address;
      logic [8:0]  free_blocks;
      logic [8:0]  used_blocks;
      logic [8:0]  peak_used_blocks;
      logic [24:0] bytes_in_use;
   } rsp_beat_type;

   typedef struct packed {
      logic [31:0] pool_base_address;
      logic [16:0] bytes_per_block;
      logic [8:0]  blocks_in_pool;
   } cfg_type;

   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } list_ctl_type;

endpackage

// ===== src/fbpa_list_ram.sv =====
// single port synchronous ram holding the free address list
module fbpa_list_ram #(
   parameter int DEPTH = fbpa_pkg::MAX_BLOCKS_DEF,
   parameter int WIDTH = fbpa_pkg::ADDR_BITS_DEF
) (
   input  logic                     clock,
   input  fbpa_pkg::list_ctl_type   ctl,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);
   import fbpa_pkg::*;

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[addr] <= wdata;
      end
      if (ctl.rd_en) begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== src/fbpa_engine.sv =====
// request sequencer: counts, list push and pop, rebuild walk and result build
module fbpa_engine #(
   parameter int MAX_BLOCKS = fbpa_pkg::MAX_BLOCKS_DEF,
   parameter int ADDR_BITS  = fbpa_pkg::ADDR_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  fbpa_pkg::cfg_type             cfg,
   input  logic                          req_valid,
   input  fbpa_pkg::req_beat_type        req_data,
   output logic                          in_ready,
   output logic                          res_valid,
   input  logic                          res_take,
   output fbpa_pkg::rsp_beat_type        res_data,
   output fbpa_pkg::list_ctl_type        mem_ctl,
   output logic [$clog2(MAX_BLOCKS)-1:0] mem_addr,
   output logic [ADDR_BITS-1:0]          mem_wdata,
   input  logic [ADDR_BITS-1:0]          mem_rdata
);
   import fbpa_pkg::*;

   localparam int IDX_BITS  = $clog2(MAX_BLOCKS);
   localparam int CNT_BITS  = $clog2(MAX_BLOCKS + 1);
   localparam int PROD_BITS = CNT_BITS + 17;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_REBUILD,
      S_MUL,
      S_DONE
   } state_type;

   state_type              state_ff, state_in;
   req_beat_type           req_ff, req_in;
   logic [CNT_BITS-1:0]    free_ff, free_in;
   logic [CNT_BITS-1:0]    used_ff, used_in;
   logic [CNT_BITS-1:0]    peak_ff, peak_in;
   logic [IDX_BITS-1:0]    idx_ff, idx_in;
   logic [ADDR_BITS-1:0]   acc_ff, acc_in;
   logic [ADDR_BITS-1:0]   grant_ff, grant_in;
   logic [1:0]             status_ff, status_in;
   logic                   alloc_ok_ff, alloc_ok_in;
   logic [PROD_BITS-1:0]   prod_ff, prod_in;
   logic [CNT_BITS-1:0]    pool_n;
   logic [CNT_BITS-1:0]    used_inc;
   logic [24:0]            bytes;

   // pool size clipped to the list depth
   assign pool_n = ({23'b0, cfg.blocks_in_pool} > 32'(MAX_BLOCKS)) ?
                   CNT_BITS'(MAX_BLOCKS) : CNT_BITS'(cfg.blocks_in_pool);
   assign used_inc = used_ff + CNT_BITS'(1);

   always_comb begin
      state_in    = state_ff;
      req_in      = req_ff;
      free_in     = free_ff;
      used_in     = used_ff;
      peak_in     = peak_ff;
      idx_in      = idx_ff;
      acc_in      = acc_ff;
      grant_in    = grant_ff;
      status_in   = status_ff;
      alloc_ok_in = alloc_ok_ff;
      prod_in     = prod_ff;
      in_ready    = 1'b0;
      res_valid   = 1'b0;
      mem_ctl     = '0;
      mem_addr    = idx_ff;
      mem_wdata   = acc_ff;
      case (state_ff)
         S_IDLE: begin
            in_ready = 1'b1;
            if (req_valid) begin
               req_in      = req_data;
               status_in   = STATUS_DONE;
               alloc_ok_in = 1'b0;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_MUL;
            case (req_ff.req_type)
               REQ_ALLOC: begin
                  if (req_ff.request_bytes > {7'b0, cfg.bytes_per_block}) begin
                     status_in = STATUS_TOO_BIG;
                  end else if (free_ff == '0) begin
                     status_in = STATUS_EXHAUSTED;
                  end else begin
                     free_in       = free_ff - CNT_BITS'(1);
                     used_in       = used_inc;
                     alloc_ok_in   = 1'b1;
                     mem_ctl.rd_en = 1'b1;
                     mem_addr      = IDX_BITS'(free_ff - CNT_BITS'(1));
                     if (used_inc > peak_ff) begin
                        peak_in = used_inc;
                     end
                  end
               end
               REQ_FREE: begin
                  if (free_ff >= pool_n) begin
                     status_in = STATUS_FULL;
                  end else begin
                     mem_ctl.wr_en = 1'b1;
                     mem_addr      = IDX_BITS'(free_ff);
                     mem_wdata     = ADDR_BITS'(req_ff.returned_address);
                     free_in       = free_ff + CNT_BITS'(1);
                     if (used_ff != '0) begin
                        used_in = used_ff - CNT_BITS'(1);
                     end
                  end
               end
               REQ_REBUILD: begin
                  free_in = pool_n;
                  used_in = '0;
                  idx_in  = '0;
                  acc_in  = ADDR_BITS'(cfg.pool_base_address);
                  if (pool_n != '0) begin
                     state_in = S_REBUILD;
                  end
               end
               default: begin
               end
            endcase
         end
         S_REBUILD: begin
            mem_ctl.wr_en = 1'b1;
            acc_in        = acc_ff + ADDR_BITS'(cfg.bytes_per_block);
            idx_in        = idx_ff + IDX_BITS'(1);
            if (idx_ff == IDX_BITS'(pool_n - CNT_BITS'(1))) begin
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            prod_in  = PROD_BITS'(used_ff) * PROD_BITS'(cfg.bytes_per_block);
            grant_in = alloc_ok_ff ? mem_rdata : '0;
            state_in = S_DONE;
         end
         S_DONE: begin
            res_valid = 1'b1;
            if (res_take) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         free_ff  <= '0;
         used_ff  <= '0;
         peak_ff  <= '0;
      end else begin
         state_ff <= state_in;
         free_ff  <= free_in;
         used_ff  <= used_in;
         peak_ff  <= peak_in;
      end
      req_ff      <= req_in;
      idx_ff      <= idx_in;
      acc_ff      <= acc_in;
      grant_ff    <= grant_in;
      status_ff   <= status_in;
      alloc_ok_ff <= alloc_ok_in;
      prod_ff     <= prod_in;
   end

   // saturate bytes in use
   assign bytes = (prod_ff > PROD_BITS'(BYTES_MAX)) ? BYTES_MAX : 25'(prod_ff);

   always_comb begin
      res_data.status           = status_ff;
      res_data.block_address    = 32'(grant_ff);
      res_data.free_blocks      = 9'(free_ff);
      res_data.used_blocks      = 9'(used_ff);
      res_data.peak_used_blocks = 9'(peak_ff);
      res_data.bytes_in_use     = bytes;
   end

   assert property (@(posedge clock) disable iff (reset)
      free_ff <= CNT_BITS'(MAX_BLOCKS))
      else $error("free count beyond list depth");

   assert property (@(posedge clock) disable iff (reset)
      mem_ctl.wr_en |-> (state_ff == S_EXEC || state_ff == S_REBUILD))
      else $error("list write outside push or rebuild");

   assert property (@(posedge clock) disable iff (reset)
      mem_ctl.rd_en |=> (state_ff == S_MUL && alloc_ok_ff))
      else $error("popped entry not captured next cycle");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_REBUILD) |-> (CNT_BITS'(idx_ff) < pool_n))
      else $error("rebuild walk past pool size");

endmodule

// ===== src/fixed_block_pool_allocator_core.sv =====
// Fixed block pool allocator top level: csr registers, engine, list ram and result register.
// Allocate, free and unused request codes pass from accepted beat to result loaded in the output
// register through the sequencer step with the list ram access, the bytes multiply and the
// result load; the engine takes no new request beat until that result is loaded. A rebuild
// walks the pool blocks between the sequencer step and the bytes multiply, the list ram taking
// one write per cycle. A result stalled in the output register holds the next result, and so
// the input, until it drains. After reset the free list is empty: configure the registers,
// then issue a rebuild request before allocating.
module fixed_block_pool_allocator_core #(
   parameter int MAX_BLOCKS = fbpa_pkg::MAX_BLOCKS_DEF,
   parameter int ADDR_BITS  = fbpa_pkg::ADDR_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  fbpa_pkg::req_beat_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output fbpa_pkg::rsp_beat_type rsp_data,
   input  logic                   csr_we,
   input  logic [1:0]             csr_index,
   input  logic [31:0]            csr_wdata
);
   import fbpa_pkg::*;

   localparam int IDX_BITS = $clog2(MAX_BLOCKS);

   cfg_type               cfg_ff;
   logic                  rsp_valid_ff;
   rsp_beat_type          rsp_data_ff;
   logic                  in_ready;
   logic                  res_valid;
   logic                  res_take;
   rsp_beat_type          res_data;
   list_ctl_type          mem_ctl;
   logic [IDX_BITS-1:0]   mem_addr;
   logic [ADDR_BITS-1:0]  mem_wdata;
   logic [ADDR_BITS-1:0]  mem_rdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pool_base_address <= '0;
         cfg_ff.bytes_per_block   <= 17'd64;
         cfg_ff.blocks_in_pool    <= 9'd256;
      end else if (csr_we) begin
         case (csr_index)
            CSR_POOL_BASE:   cfg_ff.pool_base_address <= csr_wdata;
            CSR_BLOCK_BYTES: cfg_ff.bytes_per_block   <= csr_wdata[16:0];
            CSR_POOL_BLOCKS: cfg_ff.blocks_in_pool    <= csr_wdata[8:0];
            default: begin
            end
         endcase
      end
   end

   assign res_take = res_valid && (!rsp_valid_ff || !rsp_stall);

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_take) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (res_take) begin
         rsp_data_ff <= res_data;
      end
   end

   assign req_stall = !in_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   fbpa_engine #(
      .MAX_BLOCKS (MAX_BLOCKS),
      .ADDR_BITS  (ADDR_BITS)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_valid (req_valid),
      .req_data  (req_data),
      .in_ready  (in_ready),
      .res_valid (res_valid),
      .res_take  (res_take),
      .res_data  (res_data),
      .mem_ctl   (mem_ctl),
      .mem_addr  (mem_addr),
      .mem_wdata (mem_wdata),
      .mem_rdata (mem_rdata)
   );

   fbpa_list_ram #(
      .DEPTH (MAX_BLOCKS),
      .WIDTH (ADDR_BITS)
   ) u_list_ram (
      .clock (clock),
      .ctl   (mem_ctl),
      .addr  (mem_addr),
      .wdata (mem_wdata),
      .rdata (mem_rdata)
   );

endmodule

// ===== test/tb.sv =====
// testbench for the fixed block pool allocator core: predicted results checked beat by beat
`timescale 1ns / 1ps

module tb;
   import fbpa_pkg::*;

   localparam logic [1:0] REQ_UNUSED = 2'd3;
   localparam int         POOL_MAX   = MAX_BLOCKS_DEF;

   class pool_ledger;
      logic [31:0]  base_addr;
      logic [16:0]  blk_bytes;
      logic [8:0]   pool_blocks;
      logic [31:0]  addr_stack [POOL_MAX];
      int unsigned  free_cnt;
      int unsigned  used_cnt;
      int unsigned  peak_cnt;
      rsp_beat_type awaited_rsp [$];
      int           mismatches;

      function new();
         base_addr   = '0;
         blk_bytes   = 17'd64;
         pool_blocks = 9'd256;
         free_cnt    = 0;
         used_cnt    = 0;
         peak_cnt    = 0;
         mismatches  = 0;
         foreach (addr_stack[i]) addr_stack[i] = '0;
      endfunction

      function void configure(logic [1:0] idx, logic [31:0] val);
         case (idx)
            CSR_POOL_BASE:   base_addr   = val;
            CSR_BLOCK_BYTES: blk_bytes   = val[16:0];
            CSR_POOL_BLOCKS: pool_blocks = val[8:0];
            default: ;
         endcase
      endfunction

      function int unsigned pool_size();
         if (32'(pool_blocks) > POOL_MAX) return POOL_MAX;
         return 32'(pool_blocks);
      endfunction

      function rsp_beat_type note_request(req_beat_type r);
         rsp_beat_type     e;
         int unsigned      n;
         longint unsigned  prod;
         e = '0;
         e.status = STATUS_DONE;
         n = pool_size();
         case (r.req_type)
            REQ_ALLOC: begin
               if (r.request_bytes > 24'(blk_bytes)) begin
                  e.status = STATUS_TOO_BIG;
               end else if (free_cnt == 0) begin
                  e.status = STATUS_EXHAUSTED;
               end else begin
                  free_cnt--;
                  e.block_address = addr_stack[free_cnt];
                  used_cnt++;
                  if (used_cnt > peak_cnt) peak_cnt = used_cnt;
               end
            end
            REQ_FREE: begin
               if (free_cnt >= n || free_cnt >= POOL_MAX) begin
                  e.status = STATUS_FULL;
               end else begin
                  addr_stack[free_cnt] = r.returned_address;
                  free_cnt++;
                  if (used_cnt > 0) used_cnt--;
               end
            end
            REQ_REBUILD: begin
               for (int i = 0; i < n; i++) begin
                  addr_stack[i] = base_addr + 32'(i * int'(blk_bytes));
               end
               free_cnt = n;
               used_cnt = 0;
            end
            default: ;
         endcase
         prod = longint'(used_cnt) * longint'(blk_bytes);
         if (prod > 64'(BYTES_MAX)) prod = 64'(BYTES_MAX);
         e.free_blocks      = free_cnt[8:0];
         e.used_blocks      = used_cnt[8:0];
         e.peak_used_blocks = peak_cnt[8:0];
         e.bytes_in_use     = prod[24:0];
         awaited_rsp.push_back(e);
         return e;
      endfunction

      function bit field_ok(string name, logic [31:0] want, logic [31:0] got);
         if (got === want) return 1'b1;
         if (mismatches < 10) begin
            $display("%0t: %s expected %h got %h", $realtime, name, want, got);
         end
         return 1'b0;
      endfunction

      function void check_response(rsp_beat_type got);
         rsp_beat_type want;
         bit           ok;
         if (awaited_rsp.size() == 0) begin
            if (mismatches < 10) $display("%0t: unexpected result beat %h", $realtime, got);
            mismatches++;
            return;
         end
         want = awaited_rsp.pop_front();
         ok = field_ok("status", 32'(want.status), 32'(got.status));
         ok &= field_ok("block_address", want.block_address, got.block_address);
         ok &= field_ok("free_blocks", 32'(want.free_blocks), 32'(got.free_blocks));
         ok &= field_ok("used_blocks", 32'(want.used_blocks), 32'(got.used_blocks));
         ok &= field_ok("peak_used_blocks", 32'(want.peak_used_blocks),
                        32'(got.peak_used_blocks));
         ok &= field_ok("bytes_in_use", 32'(want.bytes_in_use), 32'(got.bytes_in_use));
         if (!ok) mismatches++;
      endfunction

      function int pending();
         return awaited_rsp.size();
      endfunction
   endclass

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_beat_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_beat_type rsp_data;
   logic         csr_we = 1'b0;
   logic [1:0]   csr_index = CSR_POOL_BASE;
   logic [31:0]  csr_wdata = '0;

   pool_ledger   ledger;
   logic [31:0]  granted [$];
   int           send_idle_pct = 0;
   int           recv_stall_pct = 0;

   fixed_block_pool_allocator_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   always @(negedge clock) begin
      rsp_stall <= reset ? 1'b0 : ($urandom_range(0, 99) < recv_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) ledger.check_response(rsp_data);
   end

   task automatic issue(logic [1:0] kind, logic [23:0] nbytes, logic [31:0] addr);
      req_beat_type b;
      rsp_beat_type want;
      bit           taken;
      b.req_type         = kind;
      b.request_bytes    = nbytes;
      b.returned_address = addr;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_data  = b;
      taken = 1'b0;
      while (!taken) begin
         @(posedge clock);
         taken = !req_stall;
      end
      want = ledger.note_request(b);
      if (kind == REQ_ALLOC && want.status == STATUS_DONE) granted.push_back(want.block_address);
      if (kind == REQ_REBUILD) granted.delete();
      @(negedge clock);
   endtask

   task automatic wait_idle();
      req_valid = 1'b0;
      while (ledger.pending() != 0) @(negedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [31:0] val);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      ledger.configure(idx, val);
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   // upper bits beyond each register's width carry noise
   task automatic set_pool(logic [31:0] base, logic [16:0] nbytes, logic [8:0] nblocks);
      wait_idle();
      write_csr(CSR_POOL_BASE, base);
      write_csr(CSR_BLOCK_BYTES, ($urandom & ~32'h1FFFF) | 32'(nbytes));
      write_csr(CSR_POOL_BLOCKS, ($urandom & ~32'h1FF) | 32'(nblocks));
   endtask

   initial begin
      #20ms;
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      int          pick;
      int          idx;
      logic [23:0] nb;
      logic [31:0] ad;
      logic [16:0] blk;
      ledger = new();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // empty list after reset, unused code, free with nothing handed out
      issue(REQ_ALLOC, 24'd0, $urandom);
      issue(REQ_UNUSED, 24'hFFFFFF, 32'hFFFFFFFF);
      issue(REQ_FREE, 24'($urandom), 32'hA5A55A5A);
      issue(REQ_ALLOC, 24'd64, 32'h0);
      issue(REQ_ALLOC, 24'd65, $urandom);

      // 64 KiB blocks, addresses wrapping past the top
      set_pool(32'hFFFFFF00, 17'h10000, 9'd4);
      issue(REQ_REBUILD, 24'($urandom), $urandom);
      issue(REQ_ALLOC, 24'h010000, $urandom);
      issue(REQ_ALLOC, 24'hFFFFFF, $urandom);
      repeat (3) issue(REQ_ALLOC, 24'($urandom_range(0, 65536)), $urandom);
      issue(REQ_ALLOC, 24'd0, $urandom);
      issue(REQ_FREE, 24'($urandom), 32'hFFFFFFFF);
      issue(REQ_FREE, 24'($urandom), 32'h00000000);
      issue(REQ_FREE, 24'($urandom), 32'h5A5AA5A5);
      issue(REQ_FREE, 24'($urandom), 32'h12345678);
      issue(REQ_FREE, 24'($urandom), 32'h87654321);

      // pool shrunk below the list contents
      set_pool(32'hFFFFFF00, 17'h10000, 9'd2);
      issue(REQ_FREE, 24'($urandom), $urandom);
      issue(REQ_ALLOC, 24'd1, $urandom);

      // zero block size and empty pool
      set_pool(32'hFFFFFF00, 17'd0, 9'd0);
      issue(REQ_ALLOC, 24'd1, $urandom);
      issue(REQ_ALLOC, 24'd0, $urandom);
      issue(REQ_REBUILD, 24'($urandom), $urandom);
      issue(REQ_FREE, 24'($urandom), $urandom);
      issue(REQ_ALLOC, 24'd0, $urandom);

      // pool size above the list depth
      set_pool(32'h12345678, 17'd0, 9'd511);
      issue(REQ_REBUILD, 24'($urandom), $urandom);
      issue(REQ_ALLOC, 24'd0, $urandom);

      for (int ph = 0; ph < 8; ph++) begin
         case (ph % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
            default: begin send_idle_pct = 15; recv_stall_pct = 15; end
         endcase
         case (ph)
            0: set_pool($urandom, 17'($urandom_range(1, 256)), 9'($urandom_range(1, 8)));
            1: set_pool(32'hFFFFFFFF, 17'h10000, 9'd256);
            2: set_pool(32'h00000000, 17'd1, 9'd1);
            3: set_pool($urandom, 17'($urandom_range(1, 65536)), 9'($urandom_range(1, 16)));
            4: set_pool($urandom, 17'h10000, 9'($urandom_range(257, 511)));
            5: set_pool($urandom, 17'($urandom_range(1, 4)), 9'($urandom_range(2, 6)));
            6: set_pool($urandom, 17'd0, 9'($urandom_range(0, 3)));
            default: set_pool($urandom, 17'($urandom_range(1, 65536)),
                              9'($urandom_range(1, 32)));
         endcase
         blk = ledger.blk_bytes;
         issue(REQ_REBUILD, 24'($urandom), $urandom);
         repeat (80) begin
            pick = $urandom_range(0, 99);
            if (pick < 44) begin
               if ($urandom_range(0, 99) < 85) nb = 24'($urandom_range(0, 32'(blk)));
               else nb = 24'($urandom);
               issue(REQ_ALLOC, nb, $urandom);
            end else if (pick < 86) begin
               if (granted.size() != 0 && $urandom_range(0, 99) < 80) begin
                  idx = $urandom_range(0, granted.size() - 1);
                  ad  = granted[idx];
                  granted.delete(idx);
               end else begin
                  ad = $urandom;
               end
               issue(REQ_FREE, 24'($urandom), ad);
            end else if (pick < 93) begin
               nb = 24'(blk) + 24'($urandom_range(0, 1));
               issue(REQ_ALLOC, nb, $urandom);
            end else if (pick < 96) begin
               issue(REQ_REBUILD, 24'($urandom), $urandom);
            end else begin
               issue(REQ_UNUSED, 24'($urandom), $urandom);
            end
         end
      end

      wait_idle();
      repeat (20) @(negedge clock);
      if (ledger.mismatches == 0 && ledger.pending() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
